>>> hdl/rai_pkg.sv
// Package for the register ALU instruction execute block.
// Holds the word and instruction types and the opcode, operation and error codes.
// Depends on nothing; every other file of the block but rai_ram imports it.
`default_nettype none

package rai_pkg;

   localparam int WORD_W = 16;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [WORD_W-1:0]        raw_word_type;
   typedef logic [2:0]               reg_num_type;

   // Instruction layout, most significant field first.
   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  operation;
      logic        imm;
      reg_num_type dest;
      reg_num_type src2;
      reg_num_type src1;
   } instr_type;

   localparam logic [2:0] OPC_HALT = 3'd0;
   localparam logic [2:0] OPC_MOVE = 3'd1;
   localparam logic [2:0] OPC_ALU  = 3'd2;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_MOD  = 3'd4;
   localparam logic [2:0] OP_RSUB = 3'd5;
   localparam logic [2:0] OP_RMOD = 3'd6;
   localparam logic [2:0] OP_RDIV = 3'd7;

   localparam logic ERR_NONE     = 1'b0;
   localparam logic ERR_DIV_ZERO = 1'b1;

   localparam logic [1:0] WORDS_ONE = 2'd1;
   localparam logic [1:0] WORDS_TWO = 2'd2;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic     done;
      word_type quotient;
      word_type remainder;
   } div_result_type;

endpackage

`default_nettype wire

>>> hdl/rai_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on rai_pkg for the word types.
`default_nettype none

interface rai_req_if;
   import rai_pkg::*;

   logic         valid;
   logic         ready;
   raw_word_type instruction_word;
   word_type     immediate_word;

   modport source (output valid, output instruction_word, output immediate_word, input ready);
   modport sink   (input valid, input instruction_word, input immediate_word, output ready);
endinterface

interface rai_rsp_if;
   import rai_pkg::*;

   logic        valid;
   logic        ready;
   logic        halted;
   word_type    halt_value;
   logic        write_enable;
   reg_num_type write_register;
   word_type    write_value;
   logic [1:0]  words_used;
   logic        error_code;

   modport source (output valid, output halted, output halt_value, output write_enable,
                   output write_register, output write_value, output words_used,
                   output error_code, input ready);
   modport sink   (input valid, input halted, input halt_value, input write_enable,
                   input write_register, input write_value, input words_used,
                   input error_code, output ready);
endinterface

`default_nettype wire

>>> hdl/register_alu_instruction_execute.sv
// Executes one instruction beat at a time against eight signed 16-bit registers and
// returns one result beat per instruction. Add, subtract, multiply, move, halt, no-op and
// divide-by-zero instructions go from idle through the execute and done states back to
// idle; divide and modulo with a nonzero divisor also wait in the divide state on the
// shared divider that produces one quotient bit per cycle. The register file reads through
// a registered RAM port, with data in the cycle after the beat is taken; a result waiting
// on the output stalls the done state only when the next result is ready first. After
// reset all registers read as zero. Once a halt executes, later beats write nothing.
// Depends on rai_pkg, rai_if, rai_ram and rai_div.
`default_nettype none

module register_alu_instruction_execute #(
   parameter int REGISTER_COUNT = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   rai_req_if.sink   req_bus,
   rai_rsp_if.source rsp_bus
);
   import rai_pkg::*;

   localparam int IDX_W = $clog2(REGISTER_COUNT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                state_ff, state_in;
   instr_type                 instr_ff;
   word_type                  imm_ff;
   logic                      halted_ff, halted_in;
   logic [REGISTER_COUNT-1:0] valid_ff, valid_in;
   logic                      rv_a_ff, rv_b_ff;

   logic                      p_halt_ff, p_halt_in;
   word_type                  p_hv_ff,   p_hv_in;
   logic                      p_we_ff,   p_we_in;
   word_type                  p_wval_ff, p_wval_in;
   logic                      p_err_ff,  p_err_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_halted_ff, out_halted_in;
   word_type                  out_hv_ff, out_hv_in;
   logic                      out_we_ff, out_we_in;
   reg_num_type               out_wreg_ff, out_wreg_in;
   word_type                  out_wval_ff, out_wval_in;
   logic [1:0]                out_words_ff, out_words_in;
   logic                      out_err_ff, out_err_in;

   logic                      accept;
   instr_type                 req_instr;
   logic                      ram_we;
   logic [WORD_W-1:0]         rd_a, rd_b;
   word_type                  a_val, s1_val, b_val;
   word_type                  num, den;
   logic                      swap;
   logic signed [2*WORD_W-1:0] product;
   logic                      div_start;
   div_result_type            div_res;

   assign req_instr     = instr_type'(req_bus.instruction_word);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // Port A reads the second source, port B the first.
   rai_ram #(
      .WIDTH (WORD_W),
      .DEPTH (REGISTER_COUNT)
   ) u_regs (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (instr_ff.dest[IDX_W-1:0]),
      .wr_data   (p_wval_ff),
      .rd_en     (accept),
      .rd_addr_a (req_instr.src2[IDX_W-1:0]),
      .rd_addr_b (req_instr.src1[IDX_W-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   rai_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num),
      .denominator (den),
      .result      (div_res)
   );

   always_comb begin
      a_val   = rv_a_ff ? word_type'(rd_a) : '0;
      s1_val  = rv_b_ff ? word_type'(rd_b) : '0;
      b_val   = instr_ff.imm ? imm_ff : s1_val;
      swap    = (instr_ff.operation == OP_RMOD) || (instr_ff.operation == OP_RDIV);
      num     = swap ? b_val : a_val;
      den     = swap ? a_val : b_val;
      product = a_val * b_val;
   end

   always_comb begin
      state_in      = state_ff;
      halted_in     = halted_ff;
      valid_in      = valid_ff;
      p_halt_in     = p_halt_ff;
      p_hv_in       = p_hv_ff;
      p_we_in       = p_we_ff;
      p_wval_in     = p_wval_ff;
      p_err_in      = p_err_ff;
      div_start     = 1'b0;
      ram_we        = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_halted_in = out_halted_ff;
      out_hv_in     = out_hv_ff;
      out_we_in     = out_we_ff;
      out_wreg_in   = out_wreg_ff;
      out_wval_in   = out_wval_ff;
      out_words_in  = out_words_ff;
      out_err_in    = out_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            p_halt_in = 1'b0;
            p_hv_in   = '0;
            p_we_in   = 1'b0;
            p_wval_in = '0;
            p_err_in  = ERR_NONE;
            state_in  = ST_DONE;
            if (!halted_ff) begin
               unique case (instr_ff.opcode)
                  OPC_HALT: begin
                     p_halt_in = 1'b1;
                     p_hv_in   = b_val;
                  end
                  OPC_MOVE: begin
                     p_we_in   = 1'b1;
                     p_wval_in = b_val;
                  end
                  OPC_ALU: begin
                     unique case (instr_ff.operation) inside
                        OP_ADD: begin
                           p_we_in   = 1'b1;
                           p_wval_in = a_val + b_val;
                        end
                        OP_SUB: begin
                           p_we_in   = 1'b1;
                           p_wval_in = a_val - b_val;
                        end
                        OP_MUL: begin
                           p_we_in   = 1'b1;
                           p_wval_in = word_type'(product[WORD_W-1:0]);
                        end
                        OP_RSUB: begin
                           p_we_in   = 1'b1;
                           p_wval_in = b_val - a_val;
                        end
                        OP_DIV, OP_MOD, OP_RMOD, OP_RDIV: begin
                           if (den == '0) begin
                              p_err_in = ERR_DIV_ZERO;
                           end else begin
                              div_start = 1'b1;
                              state_in  = ST_DIV;
                           end
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               p_we_in = 1'b1;
               if (instr_ff.operation == OP_DIV || instr_ff.operation == OP_RDIV) begin
                  p_wval_in = div_res.quotient;
               end else begin
                  p_wval_in = div_res.remainder;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The register write and the result beat happen together, once the output is free.
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in  = 1'b1;
               out_halted_in = halted_ff || p_halt_ff;
               out_hv_in     = p_hv_ff;
               out_we_in     = p_we_ff;
               out_wreg_in   = p_we_ff ? instr_ff.dest : '0;
               out_wval_in   = p_wval_ff;
               out_words_in  = instr_ff.imm ? WORDS_TWO : WORDS_ONE;
               out_err_in    = p_err_ff;
               halted_in     = halted_ff || p_halt_ff;
               if (p_we_ff) begin
                  ram_we = 1'b1;
                  valid_in[instr_ff.dest[IDX_W-1:0]] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         halted_ff    <= 1'b0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         instr_ff <= req_instr;
         imm_ff   <= req_bus.immediate_word;
         rv_a_ff  <= valid_ff[req_instr.src2[IDX_W-1:0]];
         rv_b_ff  <= valid_ff[req_instr.src1[IDX_W-1:0]];
      end
      p_halt_ff     <= p_halt_in;
      p_hv_ff       <= p_hv_in;
      p_we_ff       <= p_we_in;
      p_wval_ff     <= p_wval_in;
      p_err_ff      <= p_err_in;
      out_halted_ff <= out_halted_in;
      out_hv_ff     <= out_hv_in;
      out_we_ff     <= out_we_in;
      out_wreg_ff   <= out_wreg_in;
      out_wval_ff   <= out_wval_in;
      out_words_ff  <= out_words_in;
      out_err_ff    <= out_err_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.halted         = out_halted_ff;
   assign rsp_bus.halt_value     = out_hv_ff;
   assign rsp_bus.write_enable   = out_we_ff;
   assign rsp_bus.write_register = out_wreg_ff;
   assign rsp_bus.write_value    = out_wval_ff;
   assign rsp_bus.words_used     = out_words_ff;
   assign rsp_bus.error_code     = out_err_ff;

endmodule

`default_nettype wire

>>> hdl/rai_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
`default_nettype none

module rai_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> hdl/rai_div.sv
// Iterative signed 16-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on rai_pkg for the word and result types.
`default_nettype none

module rai_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire rai_pkg::word_type       numerator,
   input  wire rai_pkg::word_type       denominator,
   output rai_pkg::div_result_type      result
);
   import rai_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WORD_W-1:0]   rem_ff,   rem_in;
   logic [WORD_W-1:0]   quo_ff,   quo_in;
   logic [WORD_W-1:0]   den_ff,   den_in;
   logic                q_neg_ff, q_neg_in;
   logic                r_neg_ff, r_neg_in;

   logic [WORD_W:0]     shifted;
   logic [WORD_W:0]     trial;

   // The magnitude of -32768 is 32768, which still fits an unsigned word.
   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      trial   = shifted - {1'b0, den_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      q_neg_in = q_neg_ff;
      r_neg_in = r_neg_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = numerator[WORD_W-1] ? WORD_W'(-numerator) : WORD_W'(numerator);
         den_in   = denominator[WORD_W-1] ? WORD_W'(-denominator) : WORD_W'(denominator);
         q_neg_in = numerator[WORD_W-1] ^ denominator[WORD_W-1];
         r_neg_in = numerator[WORD_W-1];
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      q_neg_ff <= q_neg_in;
      r_neg_ff <= r_neg_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = q_neg_ff ? word_type'(-quo_ff) : word_type'(quo_ff);
   assign result.remainder = r_neg_ff ? word_type'(-rem_ff) : word_type'(rem_ff);

endmodule

`default_nettype wire

>>> hdl/rai_checker.sv
// Port-level checks on the result channel of the instruction execute block.
// Depends on rai_pkg; bound to register_alu_instruction_execute at the end of the file.
`default_nettype none

module rai_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 halted,
   input wire rai_pkg::word_type    halt_value,
   input wire logic                 write_enable,
   input wire rai_pkg::reg_num_type write_register,
   input wire rai_pkg::word_type    write_value,
   input wire logic [1:0]           words_used,
   input wire logic                 error_code
);
   import rai_pkg::*;

   // No result beat may be pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat pending after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(write_value) && $stable(halted)
                                  && $stable(write_enable) && $stable(error_code))
      else $error("stalled result beat changed");

   // A register write never comes with a halt or a divide error.
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && write_enable |-> !halted && error_code == ERR_NONE)
      else $error("write reported with halt or error");

   a_halt_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_value != '0 |-> halted && !write_enable)
      else $error("halt value without halt");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_enable |-> write_register == '0 && write_value == '0
                                     && (words_used == WORDS_ONE || words_used == WORDS_TWO))
      else $error("idle write fields not zero or bad length");

endmodule

bind register_alu_instruction_execute rai_checker u_rai_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .halted         (rsp_bus.halted),
   .halt_value     (rsp_bus.halt_value),
   .write_enable   (rsp_bus.write_enable),
   .write_register (rsp_bus.write_register),
   .write_value    (rsp_bus.write_value),
   .words_used     (rsp_bus.words_used),
   .error_code     (rsp_bus.error_code)
);

`default_nettype wire

>>> tb/sv/register_alu_instruction_execute_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for register_alu_instruction_execute: directed and random instruction beats.
// A scoreboard class predicts every result beat and compares it field by field.
// Depends on rai_pkg, rai_if and the block itself.

module register_alu_instruction_execute_tb;
   import rai_pkg::*;

   localparam int          REG_COUNT   = 8;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned PHASE_ITEMS = 443;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned TAIL_CYCLES = 40;

   localparam logic [2:0] OPC_NOP_3   = 3'd3;
   localparam logic [2:0] OPC_NOP_NEG = 3'b111;

   localparam word_type MOST_NEG = 16'sh8000;
   localparam word_type MOST_POS = 16'sh7FFF;

   typedef struct packed {
      logic        halted;
      word_type    halt_value;
      logic        write_enable;
      reg_num_type write_register;
      word_type    write_value;
      logic [1:0]  words_used;
      logic        error_code;
   } rsp_beat_type;

   class exec_scoreboard;
      word_type       regs [REG_COUNT];
      logic           halted_state;
      rsp_beat_type   predicted_beats [$];
      int unsigned    mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         halted_state = 1'b0;
         mismatches   = 0;
      endfunction

      // Executes the instruction on the shadow register file and queues its result.
      function void note_instruction(instr_type ins, word_type operand_word);
         rsp_beat_type want;
         int           a, b, num, den, r;
         logic         wrote;
         want  = '0;
         wrote = 1'b0;
         r     = 0;
         b     = ins.imm ? operand_word : regs[ins.src1];
         a     = regs[ins.src2];
         want.words_used = ins.imm ? WORDS_TWO : WORDS_ONE;
         want.error_code = ERR_NONE;
         if (!halted_state) begin
            case (ins.opcode)
               OPC_HALT: begin
                  halted_state    = 1'b1;
                  want.halt_value = word_type'(b);
               end
               OPC_MOVE: begin
                  r     = b;
                  wrote = 1'b1;
               end
               OPC_ALU: begin
                  // The reverse divide and modulo swap dividend and divisor.
                  num = (ins.operation >= OP_RMOD) ? b : a;
                  den = (ins.operation >= OP_RMOD) ? a : b;
                  case (ins.operation)
                     OP_ADD:  begin r = a + b; wrote = 1'b1; end
                     OP_SUB:  begin r = a - b; wrote = 1'b1; end
                     OP_MUL:  begin r = a * b; wrote = 1'b1; end
                     OP_RSUB: begin r = b - a; wrote = 1'b1; end
                     default: begin
                        if (den == 0) begin
                           want.error_code = ERR_DIV_ZERO;
                        end else begin
                           r = (ins.operation == OP_DIV || ins.operation == OP_RDIV) ?
                               num / den : num % den;
                           wrote = 1'b1;
                        end
                     end
                  endcase
               end
               default: ;
            endcase
         end
         if (wrote) begin
            regs[ins.dest]      = r[15:0];
            want.write_enable   = 1'b1;
            want.write_register = ins.dest;
            want.write_value    = r[15:0];
         end
         want.halted = halted_state;
         predicted_beats.push_back(want);
      endfunction

      function void compare_field(string field, logic signed [31:0] want_v,
                                  logic signed [31:0] got_v);
         if (want_v !== got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
            mismatches++;
         end
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (predicted_beats.size() == 0) begin
            $display("%0t: result beat expected none, got halted=%0d write_value=%0d",
                     $time, got.halted, got.write_value);
            mismatches++;
            return;
         end
         want = predicted_beats.pop_front();
         compare_field("halted", want.halted, got.halted);
         compare_field("halt_value", want.halt_value, got.halt_value);
         compare_field("write_enable", want.write_enable, got.write_enable);
         compare_field("write_register", want.write_register, got.write_register);
         compare_field("write_value", want.write_value, got.write_value);
         compare_field("words_used", want.words_used, got.words_used);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rai_req_if req_ch ();
   rai_rsp_if rsp_ch ();

   exec_scoreboard board;

   int unsigned send_idle_pct = 25;
   int unsigned recv_idle_pct = 81;
   int unsigned hold_request  = 0;
   int unsigned hold_left     = 0;

   register_alu_instruction_execute #(
      .REGISTER_COUNT (REG_COUNT)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: random back-pressure, plus a long hold-off when one is requested.
   initial begin : result_sink
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset || hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            if (hold_left > 0) hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_beat_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         seen.halted         = rsp_ch.halted;
         seen.halt_value     = rsp_ch.halt_value;
         seen.write_enable   = rsp_ch.write_enable;
         seen.write_register = rsp_ch.write_register;
         seen.write_value    = rsp_ch.write_value;
         seen.words_used     = rsp_ch.words_used;
         seen.error_code     = rsp_ch.error_code;
         board.check_result(seen);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Offers one instruction beat and returns at the edge that accepts it, with valid
   // still high so that a following beat can go out back to back.
   task automatic send_instruction(input instr_type ins, input word_type operand_word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.instruction_word <= ins;
      req_ch.immediate_word   <= operand_word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_instruction(ins, operand_word);
   endtask

   task automatic send_fields(input logic [2:0] opc, input logic [2:0] op,
                              input logic imm_flag, input reg_num_type dst,
                              input reg_num_type s2, input reg_num_type s1,
                              input word_type operand_word);
      instr_type ins;
      ins = instr_type'{opc, op, imm_flag, dst, s2, s1};
      send_instruction(ins, operand_word);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.predicted_beats.size() != 0);
   endtask

   // Mostly moves and arithmetic; the rest are no-op opcodes. Halt is kept for the end.
   function automatic instr_type random_instruction();
      instr_type   ins;
      int unsigned pick;
      ins  = instr_type'(16'($urandom));
      pick = $urandom_range(99);
      if (pick < 45)
         ins.opcode = OPC_ALU;
      else if (pick < 80)
         ins.opcode = OPC_MOVE;
      else
         ins.opcode = 3'($urandom_range(3, 7));
      return ins;
   endfunction

   // Small values make zero divisors and exact quotients common.
   function automatic word_type random_operand();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 2) begin
         case ($urandom_range(4))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return word_type'(-1);
            3:       return word_type'(0);
            default: return word_type'(1);
         endcase
      end else if (pick < 5) begin
         return word_type'(int'($urandom_range(8)) - 4);
      end
      return word_type'(16'($urandom));
   endfunction

   task automatic run_random_phase(input int unsigned count);
      instr_type   ins;
      word_type    operand_word;
      int unsigned sent_count;
      sent_count = 0;
      while (sent_count < count) begin
         ins          = random_instruction();
         operand_word = random_operand();
         send_instruction(ins, operand_word);
         sent_count++;
      end
   endtask

   initial begin : stimulus
      board = new();
      req_ch.valid            <= 1'b0;
      req_ch.instruction_word <= '0;
      req_ch.immediate_word   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Register 0 stays zero throughout the directed part and serves as a zero divisor.
      send_fields(OPC_ALU,  OP_DIV,  1'b0, 3'd1, 3'd0, 3'd0, 16'sd0);
      send_fields(OPC_MOVE, OP_ADD,  1'b1, 3'd1, 3'd0, 3'd0, MOST_POS);
      send_fields(OPC_MOVE, OP_ADD,  1'b1, 3'd2, 3'd0, 3'd0, MOST_NEG);
      send_fields(OPC_MOVE, OP_ADD,  1'b1, 3'd3, 3'd0, 3'd0, -16'sd1);
      send_fields(OPC_MOVE, OP_ADD,  1'b0, 3'd4, 3'd0, 3'd1, 16'sd0);
      send_fields(OPC_ALU,  OP_ADD,  1'b1, 3'd5, 3'd1, 3'd0, 16'sd1);
      send_fields(OPC_ALU,  OP_SUB,  1'b0, 3'd5, 3'd2, 3'd1, 16'sd0);
      send_fields(OPC_ALU,  OP_MUL,  1'b0, 3'd5, 3'd1, 3'd1, 16'sd0);
      send_fields(OPC_ALU,  OP_DIV,  1'b0, 3'd5, 3'd2, 3'd3, 16'sd0);
      send_fields(OPC_ALU,  OP_MOD,  1'b0, 3'd5, 3'd2, 3'd3, 16'sd0);
      send_fields(OPC_ALU,  OP_RSUB, 1'b1, 3'd6, 3'd2, 3'd0, 16'sd100);
      send_fields(OPC_ALU,  OP_RMOD, 1'b1, 3'd6, 3'd0, 3'd0, 16'sd5);
      send_fields(OPC_ALU,  OP_RDIV, 1'b0, 3'd6, 3'd0, 3'd1, 16'sd0);
      send_fields(OPC_ALU,  OP_MOD,  1'b1, 3'd6, 3'd1, 3'd0, 16'sd0);
      send_fields(OPC_ALU,  OP_DIV,  1'b1, 3'd7, 3'd1, 3'd0, -16'sd7);
      send_fields(OPC_ALU,  OP_MOD,  1'b1, 3'd7, 3'd2, 3'd0, 16'sd7);
      send_fields(OPC_ALU,  OP_RDIV, 1'b1, 3'd7, 3'd3, 3'd0, MOST_NEG);
      send_fields(OPC_ALU,  OP_RMOD, 1'b1, 3'd7, 3'd3, 3'd0, MOST_NEG);
      send_fields(OPC_NOP_3,   OP_ADD,  1'b1, 3'd1, 3'd2, 3'd3, 16'sd9);
      send_fields(OPC_NOP_NEG, OP_RDIV, 1'b1, 3'd7, 3'd7, 3'd7, -16'sd1);
      send_fields(OPC_ALU,  OP_MUL,  1'b1, 3'd6, 3'd2, 3'd0, -16'sd1);
      send_fields(OPC_ALU,  OP_ADD,  1'b0, 3'd7, 3'd7, 3'd7, 16'sd0);

      run_random_phase(PHASE_ITEMS);
      wait_for_results();

      send_idle_pct = 81;
      recv_idle_pct = 25;
      run_random_phase(PHASE_ITEMS);
      wait_for_results();

      // The result side holds off long enough for the block to back up its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = LONG_HOLD;
      run_random_phase(PHASE_ITEMS);
      wait_for_results();

      // Halt comes last, since no beat after it writes anything.
      send_idle_pct = 25;
      recv_idle_pct = 25;
      send_fields(OPC_HALT, OP_ADD, 1'b1, 3'd0, 3'd1, 3'd2, MOST_NEG);
      send_fields(OPC_HALT, OP_ADD, 1'b0, 3'd0, 3'd0, 3'd1, 16'sd0);
      send_fields(OPC_MOVE, OP_ADD, 1'b1, 3'd1, 3'd0, 3'd0, 16'sd55);
      send_fields(OPC_ALU,  OP_DIV, 1'b0, 3'd2, 3'd3, 3'd0, 16'sd0);
      send_fields(OPC_ALU,  OP_ADD, 1'b1, 3'd4, 3'd4, 3'd0, MOST_POS);
      wait_for_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
hdl/rai_pkg.sv
hdl/rai_if.sv
hdl/rai_ram.sv
hdl/rai_div.sv
hdl/register_alu_instruction_execute.sv
hdl/rai_checker.sv
tb/sv/register_alu_instruction_execute_tb.sv
